>>> rtl/core/lrn_pkg.sv
// Shared types, constants and the exponent root table for the LRN cross-channel block.
package lrn_pkg;

   localparam int MAX_WINDOW  = 15;
   localparam int DELAY_DEPTH = (MAX_WINDOW + 1) / 2;
   localparam int WIN_IDX_W   = $clog2(MAX_WINDOW);
   localparam int DLY_IDX_W   = $clog2(DELAY_DEPTH);
   localparam int LOG_BITS    = 20;
   localparam int DIV_STEPS   = 37;
   localparam int ROOT_W      = 31;

   typedef enum logic [1:0] {
      CSR_LOCAL_SIZE = 2'd0,
      CSR_ALPHA      = 2'd1,
      CSR_BETA       = 2'd2,
      CSR_K          = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH,
      ST_CHECK,
      ST_MUL,
      ST_DIV_LOAD,
      ST_DIV,
      ST_SCALE,
      ST_NORM,
      ST_LOG,
      ST_BMUL,
      ST_EXP_PREP,
      ST_EXP,
      ST_MMUL,
      ST_OUT,
      ST_NEXT
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       push;
      logic       flush;
      logic       mul;
      logic       div_load;
      logic       div_step;
      logic       scale;
      logic       norm_step;
      logic       z_load;
      logic       log_step;
      logic       bmul;
      logic       exp_prep;
      logic       exp_step;
      logic [4:0] idx;
      logic       mmul;
      logic       load;
      logic       last;
      logic       clear;
   } cmd_type;

   typedef struct packed {
      logic                 emit_ok;
      logic                 zero;
      logic                 norm_done;
      logic                 rsp_free;
      logic [DLY_IDX_W-1:0] pad;
   } status_type;

   // Chain of integer square roots of 2.0 in Q1.30, each taken from the previous one.
   function automatic logic [LOG_BITS*ROOT_W-1:0] build_roots();
      logic [63:0] root;
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      logic [LOG_BITS*ROOT_W-1:0] tab;
      root = 64'd1 << 31;
      tab  = '0;
      for (int i = 0; i < LOG_BITS; i++) begin
         v = root << 30;
         r = 64'd0;
         b = 64'd1 << 62;
         for (int n = 0; n < 32; n++) begin
            if (b > v) b = b >> 2;
         end
         for (int n = 0; n < 32; n++) begin
            if (b != 64'd0) begin
               if (v >= r + b) begin
                  v = v - (r + b);
                  r = (r >> 1) + b;
               end else begin
                  r = r >> 1;
               end
               b = b >> 2;
            end
         end
         root = r;
         tab[i*ROOT_W +: ROOT_W] = r[ROOT_W-1:0];
      end
      return tab;
   endfunction

   localparam logic [LOG_BITS*ROOT_W-1:0] ROOT_TABLE = build_roots();

endpackage

>>> rtl/core/lrn_datapath.sv
// Datapath: configuration registers, channel window, divider, log and exp units, result register.
module lrn_datapath import lrn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   input  logic signed [15:0] req_sample,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic signed [15:0] rsp_normalized,
   output logic              rsp_last,
   input  cmd_type           cmd,
   output status_type        status
);

   logic [3:0]  local_size_ff;
   logic [31:0] alpha_ff;
   logic [17:0] beta_ff;
   logic [23:0] k_ff;

   logic signed [15:0] in_sample_ff;
   logic [31:0] win_ff [MAX_WINDOW];
   logic [15:0] dly_ff [DELAY_DEPTH];
   logic [35:0] sum_ff;
   logic [3:0]  seen_ff;

   logic [63:0] prod_ff;
   logic [35:0] prod_hi_ff;
   logic [36:0] quo_ff;
   logic [3:0]  rem_ff;
   logic        zero_ff;
   logic [37:0] w_ff;
   logic [5:0]  e_ff;
   logic [30:0] z_ff;
   logic [19:0] frac_ff;
   logic signed [45:0] bl_ff;
   logic signed [10:0] ip_ff;
   logic [19:0] fp_ff;
   logic [30:0] acc_ff;
   logic [46:0] m_ff;

   logic              rsp_valid_ff;
   logic signed [15:0] rsp_normalized_ff;
   logic              rsp_last_ff;

   logic [3:0]  len;
   logic [DLY_IDX_W-1:0] pad;
   logic signed [31:0] sq_s;
   logic [31:0] sq;
   logic [31:0] removed;
   logic [35:0] sum_sub;
   logic [15:0] x;
   logic [15:0] x_mag;
   logic [36:0] hi;
   logic [4:0]  trial;
   logic        trial_ge;
   logic [37:0] scale;
   logic [61:0] zz;
   logic [31:0] zt;
   logic signed [6:0] e_off;
   logic signed [26:0] lg;
   logic signed [46:0] neg_bl;
   logic signed [30:0] ex;
   logic [61:0] acc_prod;
   logic [30:0] root;
   logic signed [11:0] shift_amt;
   logic [5:0]  sh6;
   logic [48:0] rnd;
   logic [48:0] mag;
   logic [15:0] result;

   assign len     = (local_size_ff == 4'd0) ? 4'd1 : local_size_ff;
   assign pad     = DLY_IDX_W'((len - 4'd1) >> 1);
   assign sq_s    = in_sample_ff * in_sample_ff;
   assign sq      = cmd.flush ? 32'd0 : sq_s;
   assign removed = win_ff[WIN_IDX_W'(len - 4'd1)];
   assign sum_sub = (sum_ff >= {4'd0, removed}) ? sum_ff - {4'd0, removed} : 36'd0;
   assign x       = dly_ff[pad];
   assign x_mag   = x[15] ? 16'(-x) : x;
   assign hi      = {1'b0, prod_hi_ff} + {5'd0, prod_ff[63:32]};
   assign trial   = {rem_ff, quo_ff[36]};
   assign trial_ge = trial >= {1'b0, len};
   assign scale   = {14'd0, k_ff} + {1'b0, quo_ff};
   assign zz      = z_ff * z_ff;
   assign zt      = zz[61:30];
   assign e_off   = $signed({1'b0, e_ff}) - 7'sd16;
   assign lg      = {e_off, frac_ff};
   assign neg_bl  = -{bl_ff[45], bl_ff};
   assign ex      = 31'(neg_bl >>> 16);
   assign root    = ROOT_TABLE[cmd.idx*ROOT_W +: ROOT_W];
   assign acc_prod = acc_ff * root;
   assign shift_amt = 12'sd30 - {ip_ff[10], ip_ff};
   assign sh6     = shift_amt[5:0];
   assign rnd     = ({2'b00, m_ff} + (49'd1 << (sh6 - 6'd1))) >> sh6;

   always_comb begin
      if (ip_ff >= 11'sd30) begin
         mag = 49'd40000;
      end else if (shift_amt > 12'sd48) begin
         mag = 49'd0;
      end else begin
         mag = rnd;
      end
      if (x[15]) begin
         result = (mag > 49'd32768) ? 16'h8000 : 16'(-mag[15:0]);
      end else begin
         result = (mag > 49'd32767) ? 16'h7fff : mag[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_size_ff <= 4'd5;
         alpha_ff      <= 32'd429497;
         beta_ff       <= 18'd49152;
         k_ff          <= 24'd65536;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOCAL_SIZE: local_size_ff <= csr_wdata[3:0];
            CSR_ALPHA:      alpha_ff      <= csr_wdata;
            CSR_BETA:       beta_ff       <= csr_wdata[17:0];
            CSR_K:          k_ff          <= csr_wdata[23:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < MAX_WINDOW; i++) win_ff[i] <= 32'd0;
         for (int i = 0; i < DELAY_DEPTH; i++) dly_ff[i] <= 16'd0;
         sum_ff  <= 36'd0;
         seen_ff <= 4'd0;
      end else if (cmd.push) begin
         for (int i = MAX_WINDOW - 1; i > 0; i--) win_ff[i] <= win_ff[i-1];
         win_ff[0] <= sq;
         for (int i = DELAY_DEPTH - 1; i > 0; i--) dly_ff[i] <= dly_ff[i-1];
         dly_ff[0] <= cmd.flush ? 16'd0 : in_sample_ff;
         sum_ff  <= sum_sub + {4'd0, sq};
         if (seen_ff != 4'd15) seen_ff <= seen_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) in_sample_ff <= req_sample;
      if (cmd.mul) begin
         prod_ff    <= alpha_ff * sum_ff[31:0];
         prod_hi_ff <= alpha_ff * sum_ff[35:32];
      end
      if (cmd.div_load) begin
         quo_ff <= hi;
         rem_ff <= 4'd0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[35:0], trial_ge};
         rem_ff <= trial_ge ? 4'(trial - {1'b0, len}) : trial[3:0];
      end
      if (cmd.scale) begin
         zero_ff <= (scale == 38'd0) || (x == 16'd0);
         w_ff    <= scale;
         e_ff    <= 6'd37;
      end else if (cmd.norm_step) begin
         w_ff <= {w_ff[36:0], 1'b0};
         e_ff <= e_ff - 6'd1;
      end
      if (cmd.z_load) begin
         z_ff    <= w_ff[37:7];
         frac_ff <= 20'd0;
      end else if (cmd.log_step) begin
         z_ff    <= zt[31] ? zt[31:1] : zt[30:0];
         frac_ff <= {frac_ff[18:0], zt[31]};
      end
      if (cmd.bmul) bl_ff <= $signed({1'b0, beta_ff}) * lg;
      if (cmd.exp_prep) begin
         ip_ff  <= ex[30:20];
         fp_ff  <= ex[19:0];
         acc_ff <= 31'd1 << 30;
      end else if (cmd.exp_step) begin
         if (fp_ff[19]) acc_ff <= acc_prod[60:30];
         fp_ff <= {fp_ff[18:0], 1'b0};
      end
      if (cmd.mmul) m_ff <= x_mag * acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_normalized_ff <= zero_ff ? 16'sd0 : result;
         rsp_last_ff       <= cmd.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_normalized   = rsp_normalized_ff;
   assign rsp_last         = rsp_last_ff;
   assign status.emit_ok   = seen_ff > {1'b0, pad};
   assign status.zero      = zero_ff;
   assign status.norm_done = w_ff[37];
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign status.pad       = pad;

endmodule

>>> rtl/core/lrn_control.sv
// Controller state machine that sequences the window update and the normalization steps.
module lrn_control import lrn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_last_channel,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [DLY_IDX_W-1:0] flush_left_ff, flush_left_in;
   logic                 item_last_ff, item_last_in;
   logic                 flushing_ff, flushing_in;
   logic                 accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      flush_left_in = flush_left_ff;
      item_last_in  = item_last_ff;
      flushing_in   = flushing_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in      = ST_PUSH;
               item_last_in  = req_last_channel;
               flush_left_in = req_last_channel ? status.pad : '0;
               flushing_in   = 1'b0;
            end
         end
         ST_PUSH:     state_in = ST_CHECK;
         ST_CHECK:    state_in = status.emit_ok ? ST_MUL : ST_NEXT;
         ST_MUL:      state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: begin
            state_in = ST_DIV;
            cnt_in   = 6'd0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) state_in = ST_SCALE;
         end
         ST_SCALE: state_in = ST_NORM;
         ST_NORM: begin
            if (status.zero) begin
               state_in = ST_OUT;
            end else if (status.norm_done) begin
               state_in = ST_LOG;
               cnt_in   = 6'd0;
            end
         end
         ST_LOG: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(LOG_BITS - 1)) state_in = ST_BMUL;
         end
         ST_BMUL:     state_in = ST_EXP_PREP;
         ST_EXP_PREP: begin
            state_in = ST_EXP;
            cnt_in   = 6'd0;
         end
         ST_EXP: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(LOG_BITS - 1)) state_in = ST_MMUL;
         end
         ST_MMUL: state_in = ST_OUT;
         ST_OUT:  if (status.rsp_free) state_in = ST_NEXT;
         ST_NEXT: begin
            if (flush_left_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               flush_left_in = flush_left_ff - 1'b1;
               flushing_in   = 1'b1;
               state_in      = ST_PUSH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      cmd.idx   = cnt_ff[4:0];
      cmd.flush = flushing_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = 1'b1;
         end
         ST_PUSH:     cmd.push = 1'b1;
         ST_CHECK:    ;
         ST_MUL:      cmd.mul = 1'b1;
         ST_DIV_LOAD: cmd.div_load = 1'b1;
         ST_DIV:      cmd.div_step = 1'b1;
         ST_SCALE:    cmd.scale = 1'b1;
         ST_NORM: begin
            if (!status.zero) begin
               if (status.norm_done) cmd.z_load = 1'b1;
               else cmd.norm_step = 1'b1;
            end
         end
         ST_LOG:      cmd.log_step = 1'b1;
         ST_BMUL:     cmd.bmul = 1'b1;
         ST_EXP_PREP: cmd.exp_prep = 1'b1;
         ST_EXP:      cmd.exp_step = 1'b1;
         ST_MMUL:     cmd.mmul = 1'b1;
         ST_OUT: begin
            cmd.load = status.rsp_free;
            cmd.last = item_last_ff && (flush_left_ff == '0);
         end
         ST_NEXT:     cmd.clear = item_last_ff && (flush_left_ff == '0);
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= 6'd0;
         flush_left_ff <= '0;
         item_last_ff  <= 1'b0;
         flushing_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         flush_left_ff <= flush_left_in;
         item_last_ff  <= item_last_in;
         flushing_ff   <= flushing_in;
      end
   end

   a_accept_push: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_PUSH)
      else $error("Accepted transaction did not start a window update.");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !status.rsp_free) |=> state_ff == ST_OUT)
      else $error("Result left the output state while the result register was busy.");

   a_log_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOG || state_ff == ST_EXP) |-> cnt_ff < 6'(LOG_BITS))
      else $error("Log or exp step count overran.");

   a_flush_only_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEXT && flush_left_ff != '0) |-> item_last_ff)
      else $error("Flush slot scheduled for a channel that is not the last.");

endmodule

>>> rtl/core/lrn_cross_channel_forward.sv
// Top level of the cross-channel local response normalization block.
// Channel samples of one pixel position are taken one transaction at a time, and each
// accepted channel is fully processed before the next is taken. A channel that produces a
// result passes through a 37-step restoring divider by the window width, a normalizing shifter
// of 0 to 37 steps, and two 20-step multiply loops (log2 by squaring and exp2 by a root table).
// When the sample or the scale is zero the log and exp loops are skipped. A channel that
// produces no result skips the arithmetic. The last channel of a position also runs
// (window width - 1) / 2 zero flush slots. A finished result waits in an output register,
// and the block goes on with its work until it has the next result ready; it then holds
// until the output register is accepted.
module lrn_cross_channel_forward import lrn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic signed [15:0] req_sample,
   input  logic              req_last_channel,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic signed [15:0] rsp_normalized,
   output logic              rsp_last
);

   cmd_type    cmd;
   status_type status;

   lrn_control u_control (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_last_channel (req_last_channel),
      .status           (status),
      .cmd              (cmd)
   );

   lrn_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_sample     (req_sample),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_normalized (rsp_normalized),
      .rsp_last       (rsp_last),
      .cmd            (cmd),
      .status         (status)
   );

endmodule
